### hdl/trc_pkg.sv
// trc_pkg: shared widths, codes, reset values and structs for the throttle remote controller
// used by trc_prep and throttle_remote_controller_top; no dependencies of its own
package trc_pkg;

    // field widths
    localparam int ADC_BITS   = 10;
    localparam int ADC_FULL   = (1 << ADC_BITS) - 1;
    localparam int THR_W      = 12;
    localparam int TIME_W     = 32;
    localparam int SEQ_W      = 16;
    localparam int STATUS_W   = 4;
    localparam int FLAG_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;

    // joystick mapping: signed span times sample, then divide by the adc full scale
    localparam int SPAN_W    = THR_W + 1;
    localparam int PROD_W    = ADC_BITS + THR_W + 1;
    localparam int MAG_W     = ADC_BITS + THR_W;
    localparam int RCP_SHIFT = 2 * ADC_BITS + 13;
    localparam int RCP_W     = ADC_BITS + 14;
    localparam longint unsigned RCP_ADC =
        ((64'd1 << RCP_SHIFT) + longint'(ADC_FULL) - 1) / longint'(ADC_FULL);

    // led phase: time modulo 3000 as (time / 8) modulo 375, plus the low three bits
    localparam int TDIV_SHIFT  = 3;
    localparam int TIME_BASE   = 375;
    localparam int T3_W        = TIME_W - TDIV_SHIFT;
    localparam int RCP_T_SHIFT = 37;
    localparam int RCP_T_W     = 29;
    localparam longint unsigned RCP_T =
        ((64'd1 << RCP_T_SHIFT) + longint'(TIME_BASE) - 1) / longint'(TIME_BASE);
    localparam int TPROD_W     = T3_W + RCP_T_W;
    localparam int TQ_W        = TPROD_W - RCP_T_SHIFT;
    localparam int TREM_W      = 9;
    localparam int PHASE_W     = TREM_W + TDIV_SHIFT;

    // led timing in milliseconds
    localparam int LED_PERIOD_MID   = 1500;
    localparam int LED_PERIOD_SHORT = 750;
    localparam int LED_ON_FAST      = 375;
    localparam int LED_BURST_TWO    = 500;
    localparam int LED_BURST_THREE  = 625;
    localparam int LED_BLINK_ON     = 125;
    localparam int LED_BLINK_STEP   = 250;

    // control constants
    localparam int HOLD_MS  = 2000;
    localparam int DEADBAND = 5;

    // reset values of the configuration registers
    localparam int RST_BATTERY_LOW  = 261;
    localparam int RST_BATTERY_DEAD = 246;
    localparam int RST_STOP         = 1500;
    localparam int RST_SLOW_REVERSE = 1250;
    localparam int RST_SLOW_FORWARD = 1750;
    localparam int RST_FAST_REVERSE = 1000;
    localparam int RST_FAST_FORWARD = 2000;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK_SLOW    = 4'd0,
        ST_OK_FAST    = 4'd1,
        ST_HW_FAULT   = 4'd2,
        ST_AWAIT      = 4'd3,
        ST_ESTOP      = 4'd4,
        ST_BOARD_LOW  = 4'd5,
        ST_BOARD_DEAD = 4'd6,
        ST_CTRL_LOW   = 4'd7,
        ST_CTRL_DEAD  = 4'd8
    } status_t;

    typedef enum logic [FLAG_W-1:0] {
        MODE_NONE = 2'd0,
        MODE_SLOW = 2'd1,
        MODE_FAST = 2'd2
    } mode_flag_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIO_FAULT  = 3'd0,
        CFG_BATTERY_LOW  = 3'd1,
        CFG_BATTERY_DEAD = 3'd2,
        CFG_STOP_SPEED   = 3'd3,
        CFG_SLOW_REVERSE = 3'd4,
        CFG_SLOW_FORWARD = 3'd5,
        CFG_FAST_REVERSE = 3'd6,
        CFG_FAST_FORWARD = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic                radio_fault;
        logic [ADC_BITS-1:0] battery_low_raw;
        logic [ADC_BITS-1:0] battery_dead_raw;
        logic [THR_W-1:0]    stop_speed;
        logic [THR_W-1:0]    slow_reverse;
        logic [THR_W-1:0]    slow_forward;
        logic [THR_W-1:0]    fast_reverse;
        logic [THR_W-1:0]    fast_forward;
    } cfg_t;

    // one request after the stateless precompute, ready for the control stage
    typedef struct packed {
        logic [TIME_W-1:0]   time_ms;
        logic [ADC_BITS-1:0] battery_raw;
        logic                switch_pressed;
        logic                ack_received;
        logic                ack_board_low;
        logic                ack_board_dead;
        logic [PHASE_W-1:0]  phase;
        logic [THR_W-1:0]    thr_slow;
        logic [THR_W-1:0]    thr_fast;
    } prep_t;

endpackage

### hdl/trc_prep.sv
// trc_prep: three-stage precompute of everything that depends only on the request and config
// led phase (time modulo 3000) and the throttle for both modes; uses trc_pkg
module trc_prep (
    input  logic                           clk,
    input  logic                           rst_n,
    input  trc_pkg::cfg_t                  cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [trc_pkg::TIME_W-1:0]     time_ms,
    input  logic [trc_pkg::ADC_BITS-1:0]   joystick,
    input  logic [trc_pkg::ADC_BITS-1:0]   battery_raw,
    input  logic                           switch_pressed,
    input  logic                           ack_received,
    input  logic                           ack_board_low,
    input  logic                           ack_board_dead,
    output logic                           prep_valid,
    input  logic                           prep_ready,
    output trc_pkg::prep_t                 prep
);

    // scaled division by the adc full scale, then offset, clamp and deadband
    function automatic logic [trc_pkg::THR_W-1:0] map_thr(
        input logic signed [trc_pkg::PROD_W-1:0] p,
        input logic [trc_pkg::THR_W-1:0]         lo,
        input logic [trc_pkg::THR_W-1:0]         stop
    );
        logic [trc_pkg::MAG_W-1:0]                   mag;
        logic [trc_pkg::MAG_W+trc_pkg::RCP_W-1:0]    qprod;
        logic [trc_pkg::THR_W-1:0]                   q;
        logic signed [trc_pkg::THR_W+1:0]            r;
        logic signed [trc_pkg::THR_W:0]              d;
        logic signed [trc_pkg::THR_W:0]              db;
        logic [trc_pkg::THR_W-1:0]                   thr;
        begin
            mag   = p[trc_pkg::PROD_W-1] ? trc_pkg::MAG_W'(-p) : trc_pkg::MAG_W'(p);
            qprod = (trc_pkg::MAG_W + trc_pkg::RCP_W)'(mag)
                  * (trc_pkg::MAG_W + trc_pkg::RCP_W)'(trc_pkg::RCP_ADC);
            q     = qprod[trc_pkg::RCP_SHIFT +: trc_pkg::THR_W];
            // truncation toward zero: subtract the magnitude quotient for a negative span
            if (p[trc_pkg::PROD_W-1])
                r = $signed({2'b00, lo}) - $signed({2'b00, q});
            else
                r = $signed({2'b00, lo}) + $signed({2'b00, q});
            if (r[trc_pkg::THR_W+1])
                thr = '0;
            else if (r[trc_pkg::THR_W])
                thr = '1;
            else
                thr = r[trc_pkg::THR_W-1:0];
            d  = $signed({1'b0, thr}) - $signed({1'b0, stop});
            db = (trc_pkg::THR_W + 1)'(trc_pkg::DEADBAND);
            if (d > -db && d < db)
                thr = stop;
            map_thr = thr;
        end
    endfunction

    // stage 1: input register
    logic                          v1_reg;
    logic                          rdy1;
    logic [trc_pkg::TIME_W-1:0]    s1_time_reg;
    logic [trc_pkg::ADC_BITS-1:0]  s1_joy_reg;
    logic [trc_pkg::ADC_BITS-1:0]  s1_batt_reg;
    logic                          s1_sw_reg;
    logic                          s1_ack_reg;
    logic                          s1_ack_low_reg;
    logic                          s1_ack_dead_reg;

    // stage 2: time quotient and span products
    logic                                 v2_reg;
    logic                                 rdy2;
    logic [trc_pkg::TIME_W-1:0]           s2_time_reg;
    logic [trc_pkg::ADC_BITS-1:0]         s2_batt_reg;
    logic                                 s2_sw_reg;
    logic                                 s2_ack_reg;
    logic                                 s2_ack_low_reg;
    logic                                 s2_ack_dead_reg;
    logic [trc_pkg::TQ_W-1:0]             s2_tq_reg;
    logic signed [trc_pkg::PROD_W-1:0]    s2_pslow_reg;
    logic signed [trc_pkg::PROD_W-1:0]    s2_pfast_reg;

    logic [trc_pkg::TPROD_W-1:0]          tprod;
    logic [trc_pkg::TQ_W-1:0]             tq_next;
    logic signed [trc_pkg::SPAN_W-1:0]    span_slow;
    logic signed [trc_pkg::SPAN_W-1:0]    span_fast;
    logic signed [trc_pkg::PROD_W-1:0]    pslow_next;
    logic signed [trc_pkg::PROD_W-1:0]    pfast_next;

    // stage 3: phase and mapped throttle
    logic                                 v3_reg;
    logic                                 rdy3;
    trc_pkg::prep_t                       s3_reg;
    trc_pkg::prep_t                       s3_next;
    logic [trc_pkg::T3_W-1:0]             tmul;
    logic [trc_pkg::T3_W-1:0]             trem;

    // per-stage ready lets bubbles fill while the output waits
    assign rdy3     = !v3_reg || prep_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (in_valid && rdy1)
        begin
            s1_time_reg     <= time_ms;
            s1_joy_reg      <= joystick;
            s1_batt_reg     <= battery_raw;
            s1_sw_reg       <= switch_pressed;
            s1_ack_reg      <= ack_received;
            s1_ack_low_reg  <= ack_board_low;
            s1_ack_dead_reg <= ack_board_dead;
        end
    end

    // reciprocal multiply for time / 3000, and the two signed span products
    always_comb
    begin
        tprod = trc_pkg::TPROD_W'(s1_time_reg[trc_pkg::TIME_W-1:trc_pkg::TDIV_SHIFT])
              * trc_pkg::TPROD_W'(trc_pkg::RCP_T);
        tq_next    = tprod[trc_pkg::RCP_T_SHIFT +: trc_pkg::TQ_W];
        span_slow  = $signed({1'b0, cfg.slow_forward}) - $signed({1'b0, cfg.slow_reverse});
        span_fast  = $signed({1'b0, cfg.fast_forward}) - $signed({1'b0, cfg.fast_reverse});
        pslow_next = trc_pkg::PROD_W'($signed({1'b0, s1_joy_reg}))
                   * trc_pkg::PROD_W'(span_slow);
        pfast_next = trc_pkg::PROD_W'($signed({1'b0, s1_joy_reg}))
                   * trc_pkg::PROD_W'(span_fast);
    end

    // stage 2 payload
    always_ff @(posedge clk)
    begin
        if (v1_reg && rdy2)
        begin
            s2_time_reg     <= s1_time_reg;
            s2_batt_reg     <= s1_batt_reg;
            s2_sw_reg       <= s1_sw_reg;
            s2_ack_reg      <= s1_ack_reg;
            s2_ack_low_reg  <= s1_ack_low_reg;
            s2_ack_dead_reg <= s1_ack_dead_reg;
            s2_tq_reg       <= tq_next;
            s2_pslow_reg    <= pslow_next;
            s2_pfast_reg    <= pfast_next;
        end
    end

    // remainder of time / 3000 and the mapped throttle for each mode
    always_comb
    begin
        tmul = trc_pkg::T3_W'(s2_tq_reg) * trc_pkg::T3_W'(trc_pkg::TIME_BASE);
        trem = s2_time_reg[trc_pkg::TIME_W-1:trc_pkg::TDIV_SHIFT] - tmul;
        s3_next.time_ms        = s2_time_reg;
        s3_next.battery_raw    = s2_batt_reg;
        s3_next.switch_pressed = s2_sw_reg;
        s3_next.ack_received   = s2_ack_reg;
        s3_next.ack_board_low  = s2_ack_low_reg;
        s3_next.ack_board_dead = s2_ack_dead_reg;
        s3_next.phase          = {trem[trc_pkg::TREM_W-1:0],
                                  s2_time_reg[trc_pkg::TDIV_SHIFT-1:0]};
        s3_next.thr_slow       = map_thr(s2_pslow_reg, cfg.slow_reverse, cfg.stop_speed);
        s3_next.thr_fast       = map_thr(s2_pfast_reg, cfg.fast_reverse, cfg.stop_speed);
    end

    // stage 3 payload
    always_ff @(posedge clk)
    begin
        if (v2_reg && rdy3)
            s3_reg <= s3_next;
    end

    assign prep_valid = v3_reg;
    assign prep       = s3_reg;

endmodule

### hdl/throttle_remote_controller_top.sv
// throttle_remote_controller_top: config registers, controller state and the result register
// uses trc_pkg and trc_prep
//
// Each request is one control tick and gives exactly one result. Requests are taken every
// cycle while out_ready does not stall the result register. A request is loaded into the
// first of three precompute stages in trc_prep, passes through the other two, then the
// control stage writes the result register. Mode, press time, switch level, sequence count
// and status live only in the control stage and are updated in the same cycle that the
// result register loads, so ticks follow back to back. The status LED uses the status held
// before the tick (forced to hardware fault while radio_fault is set). Config is written
// through cfg_valid/cfg_ready, always ready, and must only be written while no request is
// in flight.
module throttle_remote_controller_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // config write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [trc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [trc_pkg::CFG_DATA_W-1:0]    cfg_data,
    // tick request
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [trc_pkg::TIME_W-1:0]        time_ms,
    input  logic [trc_pkg::ADC_BITS-1:0]      joystick,
    input  logic [trc_pkg::ADC_BITS-1:0]      battery_raw,
    input  logic                              switch_pressed,
    input  logic                              ack_received,
    input  logic                              ack_board_low,
    input  logic                              ack_board_dead,
    // result
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              led,
    output logic                              packet_valid,
    output logic [trc_pkg::SEQ_W-1:0]         sequence_res,
    output logic [trc_pkg::FLAG_W-1:0]        mode_flag,
    output logic [trc_pkg::THR_W-1:0]         throttle,
    output logic [trc_pkg::STATUS_W-1:0]      status
);

    // led pattern for a status at a phase within the 3000 ms frame
    function automatic logic led_of(
        input trc_pkg::status_t              st,
        input logic [trc_pkg::PHASE_W-1:0]   m
    );
        logic [trc_pkg::PHASE_W-1:0] m_mid;
        logic [trc_pkg::PHASE_W-1:0] m_short;
        logic                        burst_mid;
        logic                        burst_two;
        logic                        lvl;
        begin
            m_mid   = (m >= trc_pkg::PHASE_W'(trc_pkg::LED_PERIOD_MID))
                    ? m - trc_pkg::PHASE_W'(trc_pkg::LED_PERIOD_MID) : m;
            m_short = (m_mid >= trc_pkg::PHASE_W'(trc_pkg::LED_PERIOD_SHORT))
                    ? m_mid - trc_pkg::PHASE_W'(trc_pkg::LED_PERIOD_SHORT) : m_mid;
            burst_mid = (m_mid < trc_pkg::PHASE_W'(trc_pkg::LED_BLINK_ON))
                     || (m_mid >= trc_pkg::PHASE_W'(trc_pkg::LED_BLINK_STEP)
                         && m_mid < trc_pkg::PHASE_W'(trc_pkg::LED_ON_FAST));
            burst_two = (m < trc_pkg::PHASE_W'(trc_pkg::LED_BLINK_ON))
                     || (m >= trc_pkg::PHASE_W'(trc_pkg::LED_BLINK_STEP)
                         && m < trc_pkg::PHASE_W'(trc_pkg::LED_ON_FAST));
            unique case (st)
                trc_pkg::ST_HW_FAULT:
                    lvl = m < trc_pkg::PHASE_W'(trc_pkg::LED_BURST_TWO);
                trc_pkg::ST_AWAIT:
                    lvl = burst_mid;
                trc_pkg::ST_OK_SLOW:
                    lvl = m_mid < trc_pkg::PHASE_W'(trc_pkg::LED_PERIOD_SHORT);
                trc_pkg::ST_OK_FAST:
                    lvl = m_short < trc_pkg::PHASE_W'(trc_pkg::LED_ON_FAST);
                trc_pkg::ST_ESTOP:
                    lvl = 1'b1;
                trc_pkg::ST_BOARD_LOW:
                    lvl = burst_two;
                trc_pkg::ST_BOARD_DEAD:
                    lvl = burst_two
                       || (m >= trc_pkg::PHASE_W'(trc_pkg::LED_BURST_TWO)
                           && m < trc_pkg::PHASE_W'(trc_pkg::LED_BURST_THREE));
                trc_pkg::ST_CTRL_LOW:
                    lvl = (m < trc_pkg::PHASE_W'(trc_pkg::LED_BLINK_STEP))
                       || (m >= trc_pkg::PHASE_W'(trc_pkg::LED_BURST_TWO)
                           && m < trc_pkg::PHASE_W'(trc_pkg::LED_PERIOD_SHORT));
                default:
                    lvl = 1'b0;
            endcase
            led_of = lvl;
        end
    endfunction

    trc_pkg::cfg_t                    cfg_reg;
    logic                             prep_valid;
    logic                             prep_ready;
    trc_pkg::prep_t                   prep;
    logic                             fire;

    // controller state
    logic                             fast_reg;
    logic                             fast_next;
    logic [trc_pkg::TIME_W-1:0]       press_reg;
    logic [trc_pkg::TIME_W-1:0]       press_next;
    logic                             last_sw_reg;
    logic                             last_sw_next;
    logic [trc_pkg::SEQ_W-1:0]        count_reg;
    logic [trc_pkg::SEQ_W-1:0]        count_next;
    trc_pkg::status_t                 status_reg;
    trc_pkg::status_t                 status_next;
    trc_pkg::status_t                 status_cur;
    logic [trc_pkg::TIME_W-1:0]       held;

    // result register
    logic                             out_valid_reg;
    logic                             led_reg;
    logic                             led_next;
    logic                             pkt_reg;
    logic                             pkt_next;
    logic [trc_pkg::SEQ_W-1:0]        seq_reg;
    logic [trc_pkg::SEQ_W-1:0]        seq_next;
    trc_pkg::mode_flag_t              flag_reg;
    trc_pkg::mode_flag_t              flag_next;
    logic [trc_pkg::THR_W-1:0]        thr_reg;
    logic [trc_pkg::THR_W-1:0]        thr_next;

    // config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radio_fault      <= 1'b0;
            cfg_reg.battery_low_raw  <= trc_pkg::ADC_BITS'(trc_pkg::RST_BATTERY_LOW);
            cfg_reg.battery_dead_raw <= trc_pkg::ADC_BITS'(trc_pkg::RST_BATTERY_DEAD);
            cfg_reg.stop_speed       <= trc_pkg::THR_W'(trc_pkg::RST_STOP);
            cfg_reg.slow_reverse     <= trc_pkg::THR_W'(trc_pkg::RST_SLOW_REVERSE);
            cfg_reg.slow_forward     <= trc_pkg::THR_W'(trc_pkg::RST_SLOW_FORWARD);
            cfg_reg.fast_reverse     <= trc_pkg::THR_W'(trc_pkg::RST_FAST_REVERSE);
            cfg_reg.fast_forward     <= trc_pkg::THR_W'(trc_pkg::RST_FAST_FORWARD);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (trc_pkg::cfg_idx_t'(cfg_index))
                trc_pkg::CFG_RADIO_FAULT:
                    cfg_reg.radio_fault <= cfg_data[0];
                trc_pkg::CFG_BATTERY_LOW:
                    cfg_reg.battery_low_raw <= cfg_data[trc_pkg::ADC_BITS-1:0];
                trc_pkg::CFG_BATTERY_DEAD:
                    cfg_reg.battery_dead_raw <= cfg_data[trc_pkg::ADC_BITS-1:0];
                trc_pkg::CFG_STOP_SPEED:
                    cfg_reg.stop_speed <= cfg_data[trc_pkg::THR_W-1:0];
                trc_pkg::CFG_SLOW_REVERSE:
                    cfg_reg.slow_reverse <= cfg_data[trc_pkg::THR_W-1:0];
                trc_pkg::CFG_SLOW_FORWARD:
                    cfg_reg.slow_forward <= cfg_data[trc_pkg::THR_W-1:0];
                trc_pkg::CFG_FAST_REVERSE:
                    cfg_reg.fast_reverse <= cfg_data[trc_pkg::THR_W-1:0];
                trc_pkg::CFG_FAST_FORWARD:
                    cfg_reg.fast_forward <= cfg_data[trc_pkg::THR_W-1:0];
            endcase
        end
    end

    // stateless precompute
    trc_prep u_prep (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .time_ms        (time_ms),
        .joystick       (joystick),
        .battery_raw    (battery_raw),
        .switch_pressed (switch_pressed),
        .ack_received   (ack_received),
        .ack_board_low  (ack_board_low),
        .ack_board_dead (ack_board_dead),
        .prep_valid     (prep_valid),
        .prep_ready     (prep_ready),
        .prep           (prep)
    );

    assign prep_ready = !out_valid_reg || out_ready;
    assign fire       = prep_valid && prep_ready;

    // control tick: battery, mode switch, throttle select, acknowledgement
    always_comb
    begin
        status_cur   = cfg_reg.radio_fault ? trc_pkg::ST_HW_FAULT : status_reg;
        status_next  = status_cur;
        count_next   = count_reg;
        fast_next    = fast_reg;
        press_next   = press_reg;
        last_sw_next = last_sw_reg;
        led_next     = led_of(status_cur, prep.phase);
        pkt_next     = 1'b0;
        seq_next     = count_reg;
        flag_next    = trc_pkg::MODE_NONE;
        thr_next     = '0;
        held         = '0;
        if (status_cur != trc_pkg::ST_HW_FAULT && status_cur != trc_pkg::ST_CTRL_DEAD)
        begin
            count_next = count_reg + 1'b1;
            if (prep.battery_raw <= cfg_reg.battery_low_raw)
                status_next = trc_pkg::ST_CTRL_LOW;
            if (prep.battery_raw <= cfg_reg.battery_dead_raw)
            begin
                status_next = trc_pkg::ST_CTRL_DEAD;
                seq_next    = count_next;
            end
            else
            begin
                // rising switch edge starts the hold timer
                if (!last_sw_reg && prep.switch_pressed)
                    press_next = prep.time_ms;
                held = prep.time_ms - press_next;
                if (prep.switch_pressed && held > trc_pkg::TIME_W'(trc_pkg::HOLD_MS))
                begin
                    fast_next  = !fast_reg;
                    press_next = prep.time_ms;
                    flag_next  = fast_next ? trc_pkg::MODE_FAST : trc_pkg::MODE_SLOW;
                    if (status_next == trc_pkg::ST_OK_SLOW
                        || status_next == trc_pkg::ST_OK_FAST)
                        status_next = fast_next ? trc_pkg::ST_OK_FAST : trc_pkg::ST_OK_SLOW;
                end
                last_sw_next = prep.switch_pressed;
                thr_next     = fast_next ? prep.thr_fast : prep.thr_slow;
                pkt_next     = 1'b1;
                // board battery report, low before dead
                if (prep.ack_received)
                begin
                    priority if (prep.ack_board_low)
                        status_next = trc_pkg::ST_BOARD_LOW;
                    else if (prep.ack_board_dead)
                        status_next = trc_pkg::ST_BOARD_DEAD;
                end
            end
        end
    end

    // controller state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_reg      <= 1'b0;
            press_reg     <= '0;
            last_sw_reg   <= 1'b1;
            count_reg     <= '0;
            status_reg    <= trc_pkg::ST_OK_SLOW;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (prep_ready)
                out_valid_reg <= prep_valid;
            if (fire)
            begin
                fast_reg    <= fast_next;
                press_reg   <= press_next;
                last_sw_reg <= last_sw_next;
                count_reg   <= count_next;
                status_reg  <= status_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            led_reg  <= led_next;
            pkt_reg  <= pkt_next;
            seq_reg  <= seq_next;
            flag_reg <= flag_next;
            thr_reg  <= thr_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign led          = led_reg;
    assign packet_valid = pkt_reg;
    assign sequence_res = seq_reg;
    assign mode_flag    = flag_reg;
    assign throttle     = thr_reg;
    assign status       = status_reg;

`ifndef NO_ASSERTIONS
    // a halted controller keeps its status and sequence count unless the radio faults
    a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fire && status_reg == trc_pkg::ST_CTRL_DEAD && !cfg_reg.radio_fault
        |=> status_reg == trc_pkg::ST_CTRL_DEAD && count_reg == $past(count_reg))
        else $error("halted controller changed state");

    // a sent packet never comes with a halting status
    a_pkt_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_valid
        |-> status != trc_pkg::ST_HW_FAULT && status != trc_pkg::ST_CTRL_DEAD)
        else $error("packet sent while halted");

    // a mode change is only reported with a packet
    a_flag_pkt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_flag != trc_pkg::MODE_NONE |-> packet_valid)
        else $error("mode flag without packet");

    // a tick taken while the radio faults latches the hardware fault status
    a_radio_fault: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cfg_reg.radio_fault |=> status_reg == trc_pkg::ST_HW_FAULT)
        else $error("radio fault not latched");
`endif

endmodule

### test/tb.sv
// tb: self-checking bench for throttle_remote_controller_top, one control tick per request
// depends on trc_pkg and the controller rtl; a mirror class predicts each tick's result
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_LIMIT_MS = 2000;
    localparam int STOP_BAND     = 5;
    localparam int LONG_HOLD     = 60;

    typedef struct packed {
        logic [trc_pkg::TIME_W-1:0]   time_ms;
        logic [trc_pkg::ADC_BITS-1:0] joystick;
        logic [trc_pkg::ADC_BITS-1:0] battery_raw;
        logic                         switch_pressed;
        logic                         ack_received;
        logic                         ack_board_low;
        logic                         ack_board_dead;
    } tick_t;

    typedef struct packed {
        logic                         led;
        logic                         packet_valid;
        logic [trc_pkg::SEQ_W-1:0]    sequence_res;
        logic [trc_pkg::FLAG_W-1:0]   mode_flag;
        logic [trc_pkg::THR_W-1:0]    throttle;
        logic [trc_pkg::STATUS_W-1:0] status;
    } result_t;

    // mirror of the controller state, registers and outstanding results
    class controller_mirror;
        trc_pkg::cfg_t              regs;
        logic                       fast_mode;
        logic [trc_pkg::TIME_W-1:0] press_ms;
        logic                       prev_switch;
        logic [trc_pkg::SEQ_W-1:0]  seq_count;
        trc_pkg::status_t           state_code;
        result_t                    due_results[$];
        int                         errors;

        function new();
            regs                  = '0;
            regs.battery_low_raw  = trc_pkg::ADC_BITS'(trc_pkg::RST_BATTERY_LOW);
            regs.battery_dead_raw = trc_pkg::ADC_BITS'(trc_pkg::RST_BATTERY_DEAD);
            regs.stop_speed       = trc_pkg::THR_W'(trc_pkg::RST_STOP);
            regs.slow_reverse     = trc_pkg::THR_W'(trc_pkg::RST_SLOW_REVERSE);
            regs.slow_forward     = trc_pkg::THR_W'(trc_pkg::RST_SLOW_FORWARD);
            regs.fast_reverse     = trc_pkg::THR_W'(trc_pkg::RST_FAST_REVERSE);
            regs.fast_forward     = trc_pkg::THR_W'(trc_pkg::RST_FAST_FORWARD);
            fast_mode             = 1'b0;
            press_ms              = '0;
            prev_switch           = 1'b1;
            seq_count             = '0;
            state_code            = trc_pkg::ST_OK_SLOW;
            errors                = 0;
        endfunction

        function void write_reg(trc_pkg::cfg_idx_t idx, logic [trc_pkg::CFG_DATA_W-1:0] v);
            case (idx)
                trc_pkg::CFG_RADIO_FAULT:  regs.radio_fault      = v[0];
                trc_pkg::CFG_BATTERY_LOW:  regs.battery_low_raw  = v[trc_pkg::ADC_BITS-1:0];
                trc_pkg::CFG_BATTERY_DEAD: regs.battery_dead_raw = v[trc_pkg::ADC_BITS-1:0];
                trc_pkg::CFG_STOP_SPEED:   regs.stop_speed       = v[trc_pkg::THR_W-1:0];
                trc_pkg::CFG_SLOW_REVERSE: regs.slow_reverse     = v[trc_pkg::THR_W-1:0];
                trc_pkg::CFG_SLOW_FORWARD: regs.slow_forward     = v[trc_pkg::THR_W-1:0];
                trc_pkg::CFG_FAST_REVERSE: regs.fast_reverse     = v[trc_pkg::THR_W-1:0];
                trc_pkg::CFG_FAST_FORWARD: regs.fast_forward     = v[trc_pkg::THR_W-1:0];
                default: ;
            endcase
        endfunction

        // led blink pattern per status, from the status held before the tick
        function logic blink(trc_pkg::status_t s, logic [trc_pkg::TIME_W-1:0] ms);
            logic [trc_pkg::TIME_W-1:0] m;
            case (s)
                trc_pkg::ST_HW_FAULT:   return (ms % 32'd3000) < 32'd500;
                trc_pkg::ST_AWAIT:
                begin
                    m = ms % 32'd1500;
                    return m < 32'd500 && (m % 32'd250) < 32'd125;
                end
                trc_pkg::ST_OK_SLOW:    return (ms % 32'd1500) < 32'd750;
                trc_pkg::ST_OK_FAST:    return (ms % 32'd750) < 32'd375;
                trc_pkg::ST_ESTOP:      return 1'b1;
                trc_pkg::ST_BOARD_LOW:
                begin
                    m = ms % 32'd3000;
                    return m < 32'd500 && (m % 32'd250) < 32'd125;
                end
                trc_pkg::ST_BOARD_DEAD:
                begin
                    m = ms % 32'd3000;
                    return m < 32'd750 && (m % 32'd250) < 32'd125;
                end
                trc_pkg::ST_CTRL_LOW:
                begin
                    m = ms % 32'd3000;
                    return m < 32'd1000 && (m % 32'd500) < 32'd250;
                end
                default:                return 1'b0;
            endcase
        endfunction

        // linear joystick map onto the range, truncating toward zero
        function logic [trc_pkg::THR_W-1:0] scale_stick(logic [trc_pkg::ADC_BITS-1:0] joy,
                                                        logic [trc_pkg::THR_W-1:0] lo,
                                                        logic [trc_pkg::THR_W-1:0] hi);
            longint x;
            longint span;
            longint base;
            longint r;
            x    = longint'(joy);
            span = longint'(hi);
            base = longint'(lo);
            span = span - base;
            r    = x * span / longint'(trc_pkg::ADC_FULL) + base;
            if (r < 0)
                r = 0;
            if (r > 4095)
                r = 4095;
            return r[trc_pkg::THR_W-1:0];
        endfunction

        // work out the result of one accepted tick and queue it
        function void take_tick(tick_t t);
            result_t                    r;
            logic [trc_pkg::THR_W-1:0]  thr;
            logic [trc_pkg::TIME_W-1:0] held;
            int                         gap;
            int                         stop;
            r = '0;
            if (regs.radio_fault)
                state_code = trc_pkg::ST_HW_FAULT;
            r.led          = blink(state_code, t.time_ms);
            r.sequence_res = seq_count;
            r.mode_flag    = trc_pkg::MODE_NONE;
            if (state_code != trc_pkg::ST_HW_FAULT && state_code != trc_pkg::ST_CTRL_DEAD)
            begin
                seq_count = seq_count + 1'b1;
                if (t.battery_raw <= regs.battery_low_raw)
                    state_code = trc_pkg::ST_CTRL_LOW;
                if (t.battery_raw <= regs.battery_dead_raw)
                begin
                    // dead battery consumes a sequence number and halts
                    state_code     = trc_pkg::ST_CTRL_DEAD;
                    r.sequence_res = seq_count;
                end
                else
                begin
                    // switch hold toggles the mode
                    if (!prev_switch && t.switch_pressed)
                        press_ms = t.time_ms;
                    held = t.time_ms - press_ms;
                    if (t.switch_pressed && held > trc_pkg::TIME_W'(HOLD_LIMIT_MS))
                    begin
                        fast_mode   = ~fast_mode;
                        press_ms    = t.time_ms;
                        r.mode_flag = fast_mode ? trc_pkg::MODE_FAST : trc_pkg::MODE_SLOW;
                        if (state_code == trc_pkg::ST_OK_SLOW
                            || state_code == trc_pkg::ST_OK_FAST)
                            state_code = fast_mode ? trc_pkg::ST_OK_FAST
                                                   : trc_pkg::ST_OK_SLOW;
                    end
                    prev_switch = t.switch_pressed;
                    // throttle with deadband around stop
                    thr = fast_mode ?
                          scale_stick(t.joystick, regs.fast_reverse, regs.fast_forward) :
                          scale_stick(t.joystick, regs.slow_reverse, regs.slow_forward);
                    gap  = int'(thr);
                    stop = int'(regs.stop_speed);
                    gap  = gap - stop;
                    if (gap > -STOP_BAND && gap < STOP_BAND)
                        thr = regs.stop_speed;
                    r.throttle     = thr;
                    r.packet_valid = 1'b1;
                    if (t.ack_received)
                    begin
                        if (t.ack_board_low)
                            state_code = trc_pkg::ST_BOARD_LOW;
                        else if (t.ack_board_dead)
                            state_code = trc_pkg::ST_BOARD_DEAD;
                    end
                end
            end
            r.status = state_code;
            due_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] e, logic [31:0] a);
            if (a !== e)
            begin
                $display("%0t ns: %s expected %0d got %0d", $time, name, e, a);
                errors++;
            end
        endfunction

        function void match_result(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t ns: result with none outstanding, expected none got seq %0d",
                         $time, got.sequence_res);
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare_field("led", 32'(want.led), 32'(got.led));
            compare_field("packet_valid", 32'(want.packet_valid), 32'(got.packet_valid));
            compare_field("sequence_res", 32'(want.sequence_res), 32'(got.sequence_res));
            compare_field("mode_flag", 32'(want.mode_flag), 32'(got.mode_flag));
            compare_field("throttle", 32'(want.throttle), 32'(got.throttle));
            compare_field("status", 32'(want.status), 32'(got.status));
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic                           clk            = 1'b0;
    logic                           rst_n          = 1'b0;
    logic                           cfg_valid      = 1'b0;
    logic                           cfg_ready;
    logic [trc_pkg::CFG_IDX_W-1:0]  cfg_index      = trc_pkg::CFG_RADIO_FAULT;
    logic [trc_pkg::CFG_DATA_W-1:0] cfg_data       = '0;
    logic                           in_valid       = 1'b0;
    logic                           in_ready;
    logic [trc_pkg::TIME_W-1:0]     time_ms        = '0;
    logic [trc_pkg::ADC_BITS-1:0]   joystick       = '0;
    logic [trc_pkg::ADC_BITS-1:0]   battery_raw    = '0;
    logic                           switch_pressed = 1'b0;
    logic                           ack_received   = 1'b0;
    logic                           ack_board_low  = 1'b0;
    logic                           ack_board_dead = 1'b0;
    logic                           out_valid;
    logic                           out_ready      = 1'b0;
    logic                           led;
    logic                           packet_valid;
    logic [trc_pkg::SEQ_W-1:0]      sequence_res;
    logic [trc_pkg::FLAG_W-1:0]     mode_flag;
    logic [trc_pkg::THR_W-1:0]      throttle;
    logic [trc_pkg::STATUS_W-1:0]   status;

    controller_mirror           sb;
    trc_pkg::cfg_t              cur_cfg;
    int                         send_idle_pct = 35;
    int                         recv_idle_pct = 67;
    bit                         hold_request  = 1'b0;
    logic [trc_pkg::TIME_W-1:0] clock_ms      = '0;
    logic                       switch_level  = 1'b0;

    throttle_remote_controller_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .time_ms        (time_ms),
        .joystick       (joystick),
        .battery_raw    (battery_raw),
        .switch_pressed (switch_pressed),
        .ack_received   (ack_received),
        .ack_board_low  (ack_board_low),
        .ack_board_dead (ack_board_dead),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .led            (led),
        .packet_valid   (packet_valid),
        .sequence_res   (sequence_res),
        .mode_flag      (mode_flag),
        .throttle       (throttle),
        .status         (status)
    );

    // clock
    always #2 clk = ~clk;

    // result side: check accepted results, random or long stalls
    initial
    begin
        result_t got;
        int      hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.led          = led;
                got.packet_valid = packet_valid;
                got.sequence_res = sequence_res;
                got.mode_flag    = mode_flag;
                got.throttle     = throttle;
                got.status       = status;
                sb.match_result(got);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
                out_ready   <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // offer one request, with random gaps, and note it once accepted
    task automatic send_tick(input tick_t t);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        time_ms        <= t.time_ms;
        joystick       <= t.joystick;
        battery_raw    <= t.battery_raw;
        switch_pressed <= t.switch_pressed;
        ack_received   <= t.ack_received;
        ack_board_low  <= t.ack_board_low;
        ack_board_dead <= t.ack_board_dead;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.take_tick(t);
    endtask

    task automatic send_fields(input logic [trc_pkg::TIME_W-1:0] ms, input int joy,
                               input int batt, input bit sw, input bit ack, input bit alow,
                               input bit adead);
        tick_t t;
        t.time_ms        = ms;
        t.joystick       = trc_pkg::ADC_BITS'(joy);
        t.battery_raw    = trc_pkg::ADC_BITS'(batt);
        t.switch_pressed = sw;
        t.ack_received   = ack;
        t.ack_board_low  = alow;
        t.ack_board_dead = adead;
        send_tick(t);
    endtask

    // stop offering and wait until every result is back
    task automatic wait_results_done();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // write all registers while idle
    task automatic set_registers(input int rf, input int low, input int dead, input int stop,
                                 input int sr, input int sf, input int fr, input int ff);
        trc_pkg::cfg_t                  c;
        trc_pkg::cfg_idx_t              idx;
        logic [trc_pkg::CFG_DATA_W-1:0] v;
        c.radio_fault      = rf[0];
        c.battery_low_raw  = trc_pkg::ADC_BITS'(low);
        c.battery_dead_raw = trc_pkg::ADC_BITS'(dead);
        c.stop_speed       = trc_pkg::THR_W'(stop);
        c.slow_reverse     = trc_pkg::THR_W'(sr);
        c.slow_forward     = trc_pkg::THR_W'(sf);
        c.fast_reverse     = trc_pkg::THR_W'(fr);
        c.fast_forward     = trc_pkg::THR_W'(ff);
        wait_results_done();
        for (int k = 0; k <= trc_pkg::CFG_FAST_FORWARD; k++)
        begin
            idx = trc_pkg::cfg_idx_t'(k);
            case (idx)
                trc_pkg::CFG_RADIO_FAULT:
                    v = trc_pkg::CFG_DATA_W'(c.radio_fault);
                trc_pkg::CFG_BATTERY_LOW:
                    v = trc_pkg::CFG_DATA_W'(c.battery_low_raw);
                trc_pkg::CFG_BATTERY_DEAD:
                    v = trc_pkg::CFG_DATA_W'(c.battery_dead_raw);
                trc_pkg::CFG_STOP_SPEED:   v = c.stop_speed;
                trc_pkg::CFG_SLOW_REVERSE: v = c.slow_reverse;
                trc_pkg::CFG_SLOW_FORWARD: v = c.slow_forward;
                trc_pkg::CFG_FAST_REVERSE: v = c.fast_reverse;
                default:                   v = c.fast_forward;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= v;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.write_reg(idx, v);
        end
        cfg_valid <= 1'b0;
        cur_cfg = c;
    endtask

    // battery above the low level when clean, else above the dead level and often near the low threshold
    function automatic logic [trc_pkg::ADC_BITS-1:0] pick_battery(input bit clean);
        int lo_bound;
        int v;
        lo_bound = clean ? int'(cur_cfg.battery_low_raw) : int'(cur_cfg.battery_dead_raw);
        lo_bound = lo_bound + 1;
        if (lo_bound > trc_pkg::ADC_FULL)
            return trc_pkg::ADC_BITS'($urandom_range(0, trc_pkg::ADC_FULL));
        if (!clean && $urandom_range(0, 3) == 0)
        begin
            v = int'($urandom_range(0, 4));
            v = v + int'(cur_cfg.battery_low_raw);
            v = v - 2;
            if (v < lo_bound)
                v = lo_bound;
            if (v > trc_pkg::ADC_FULL)
                v = trc_pkg::ADC_FULL;
            return trc_pkg::ADC_BITS'(v);
        end
        return trc_pkg::ADC_BITS'($urandom_range(lo_bound, trc_pkg::ADC_FULL));
    endfunction

    // running clock with held switch runs, now and then a jump anywhere
    task automatic run_ticks(input int count, input bit clean);
        tick_t t;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                clock_ms = $urandom();
            else
                clock_ms = clock_ms + $urandom_range(0, 700);
            if ($urandom_range(0, 5) == 0)
                switch_level = ~switch_level;
            t.time_ms        = clock_ms;
            t.switch_pressed = switch_level;
            if ($urandom_range(0, 3) == 0)
                t.joystick = trc_pkg::ADC_BITS'($urandom_range(490, 534));
            else
                t.joystick = trc_pkg::ADC_BITS'($urandom());
            t.battery_raw    = pick_battery(clean);
            t.ack_received   = !clean && ($urandom_range(0, 3) == 0);
            t.ack_board_low  = 1'($urandom());
            t.ack_board_dead = 1'($urandom());
            send_tick(t);
        end
    endtask

    // main sequence
    initial
    begin
        int sr;
        int sf;
        int low;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_registers(0, trc_pkg::RST_BATTERY_LOW, trc_pkg::RST_BATTERY_DEAD,
                      trc_pkg::RST_STOP, trc_pkg::RST_SLOW_REVERSE,
                      trc_pkg::RST_SLOW_FORWARD, trc_pkg::RST_FAST_REVERSE,
                      trc_pkg::RST_FAST_FORWARD);

        // range ends and deadband edges in slow mode
        send_fields(0, 0, 1023, 0, 0, 0, 0);
        send_fields(400, 1023, 1023, 0, 0, 0, 0);
        send_fields(800, 512, 1023, 0, 0, 0, 0);
        send_fields(900, 503, 512, 0, 0, 0, 0);
        send_fields(1000, 505, 700, 0, 0, 0, 0);
        send_fields(1100, 520, 300, 0, 0, 0, 0);
        send_fields(1200, 522, 262, 0, 0, 0, 0);
        // hold of exactly the limit does not toggle, one more ms does
        send_fields(1300, 700, 1023, 1, 0, 0, 0);
        send_fields(3300, 700, 1023, 1, 0, 0, 0);
        send_fields(3301, 700, 1023, 1, 0, 0, 0);
        send_fields(3400, 0, 1023, 1, 0, 0, 0);
        send_fields(3500, 1023, 1023, 0, 0, 0, 0);
        send_fields(3600, 512, 1023, 0, 0, 0, 0);
        send_fields(3700, 300, 1023, 0, 0, 0, 0);
        // hold across the time wrap
        send_fields(32'hFFFF_FF00, 100, 1023, 0, 0, 0, 0);
        send_fields(32'hFFFF_FFF0, 900, 1023, 1, 0, 0, 0);
        send_fields(32'hFFFF_FFFF, 900, 1023, 1, 0, 0, 0);
        send_fields(32'h0000_07E0, 900, 1023, 1, 0, 0, 0);
        send_fields(32'h0000_0900, 600, 1023, 0, 0, 0, 0);
        send_fields(32'h5555_5555, 400, 1023, 1, 0, 0, 0);
        send_fields(32'hAAAA_AAAA, 400, 1023, 1, 0, 0, 0);
        clock_ms = 32'h0001_0000;

        // healthy phase, no low battery and no acks
        run_ticks(100, 1'b1);

        // low battery at the threshold, board flags and their priority
        send_fields(32'h0002_0000, 600, 261, 0, 0, 0, 0);
        send_fields(32'h0002_0100, 600, 1023, 0, 1, 1, 1);
        send_fields(32'h0002_0200, 600, 1023, 0, 1, 0, 1);
        send_fields(32'h0002_0300, 600, 1023, 0, 0, 1, 1);
        send_fields(32'h0002_0400, 600, 1023, 0, 1, 0, 0);
        send_fields(32'h0002_0500, 600, 1023, 0, 1, 1, 0);

        // always low, stop at the top, reversed fast range
        set_registers(0, 1023, 0, 4095, 0, 4095, 4095, 0);
        run_ticks(100, 1'b0);

        send_idle_pct = 67;
        recv_idle_pct = 35;
        // never low, stop at zero
        set_registers(0, 0, 0, 0, 0, 100, 3, 4095);
        run_ticks(100, 1'b0);

        low = $urandom_range(1, 1023);
        set_registers(0, low, $urandom_range(0, low - 1), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 4095));
        run_ticks(100, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        low = $urandom_range(1, 1023);
        set_registers(0, low, $urandom_range(0, low - 1), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 4095));
        // long result stall while requests keep coming
        hold_request = 1'b1;
        run_ticks(100, 1'b0);

        // stop in the middle of the slow range so the deadband gets hit
        sr  = $urandom_range(0, 4095);
        sf  = $urandom_range(0, 4095);
        low = $urandom_range(1, 1023);
        set_registers(0, low, $urandom_range(0, low - 1), (sr + sf) / 2, sr, sf,
                      $urandom_range(0, 4095), $urandom_range(0, 4095));
        run_ticks(100, 1'b0);

        // dead battery at the threshold halts for good
        set_registers(0, 400, 300, 2048, 1000, 3000, 0, 4095);
        run_ticks(8, 1'b0);
        send_fields(clock_ms + 10, 512, 300, 0, 0, 0, 0);
        run_ticks(10, 1'b0);

        // radio fault overrides the halted status and sticks after clearing
        set_registers(1, 1023, 1023, 4095, 4095, 0, 4095, 0);
        run_ticks(10, 1'b0);
        set_registers(0, 1023, 1023, 4095, 4095, 0, 4095, 0);
        run_ticks(10, 1'b0);

        wait_results_done();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("throttle_remote_controller_top: match");
        else
            $display("throttle_remote_controller_top: mismatch");
        $finish;
    end

    // run limit
    initial
    begin
        #400_000;
        $display("throttle_remote_controller_top: mismatch");
        $finish;
    end

endmodule

### filelist.f
hdl/trc_pkg.sv
hdl/trc_prep.sv
hdl/throttle_remote_controller_top.sv
test/tb.sv
